@@ rtl/tcc_pkg.sv @@
// Package for the time-of-day and calendar counter.
// Holds the action codes, the clock state struct (also used for loads), the fixed
// constants and the month length table. No dependencies.
package tcc_pkg;

  localparam logic [30:0] NS_PER_SECOND   = 31'd1000000000;
  localparam logic [29:0] TICK_MAX        = 30'd999999999;
  localparam logic [29:0] TICK_RESET      = 30'd10000000;
  localparam logic [17:0] SECONDS_PER_DAY = 18'd86400;
  localparam logic [3:0]  DAYS_PER_WEEK   = 4'd7;
  localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef struct packed {
    logic [29:0] nanoseconds;
    logic [16:0] seconds;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [3:0]  month;
    logic [15:0] year;
  } clock_state_t;

  // Month length; months outside 1..12 count as 31 days.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/tcc_if.sv @@
// Channel interfaces of the time-of-day and calendar counter: load/action
// input, current-time result and tick-size configuration write.
// Depends on tcc_pkg.
interface tcc_in_if import tcc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [29:0] load_nanoseconds;
  logic [16:0] load_seconds;
  logic [4:0]  load_day;
  logic [2:0]  load_weekday;
  logic [3:0]  load_month;
  logic [15:0] load_year;

  modport source (output valid, action, load_nanoseconds, load_seconds, load_day,
                  load_weekday, load_month, load_year, input ready);
  modport sink (input valid, action, load_nanoseconds, load_seconds, load_day,
                load_weekday, load_month, load_year, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [29:0] now_nanoseconds;
  logic [16:0] now_seconds;
  logic [4:0]  now_day;
  logic [2:0]  now_weekday;
  logic [3:0]  now_month;
  logic [15:0] now_year;

  modport source (output valid, now_nanoseconds, now_seconds, now_day, now_weekday,
                  now_month, now_year, input ready);
  modport sink (input valid, now_nanoseconds, now_seconds, now_day, now_weekday,
                now_month, now_year, output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [29:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/tcc_next.sv @@
// Next-state logic of the counter: tick with second, day, month and year
// carries, load of all fields, or hold for a read or the spare code.
// Depends on tcc_pkg.
module tcc_next import tcc_pkg::*; (
  input  clock_state_t cur,
  input  clock_state_t load,
  input  logic [1:0]   action,
  input  logic [29:0]  tick_ns,
  output clock_state_t nxt
);

  logic [29:0]  step;
  logic [30:0]  ns_sum;
  logic [30:0]  ns_wrap;
  logic         sec_carry;
  logic [17:0]  sec_inc;
  logic [17:0]  sec_wrap;
  logic         day_carry;
  logic [5:0]   day_inc;
  logic [3:0]   wd_inc;
  logic [3:0]   wd_wrap;
  logic         month_roll;
  logic [4:0]   month_inc;
  logic         year_roll;
  clock_state_t ticked;

  always_comb begin
    step      = (tick_ns > TICK_MAX) ? TICK_MAX : tick_ns;
    ns_sum    = {1'b0, cur.nanoseconds} + {1'b0, step};
    sec_carry = (ns_sum >= NS_PER_SECOND);
    ns_wrap   = sec_carry ? (ns_sum - NS_PER_SECOND) : ns_sum;

    sec_inc   = {1'b0, cur.seconds} + 18'd1;
    day_carry = sec_carry && (sec_inc >= SECONDS_PER_DAY);
    sec_wrap  = (sec_inc >= SECONDS_PER_DAY) ? (sec_inc - SECONDS_PER_DAY) : sec_inc;

    day_inc    = {1'b0, cur.day} + 6'd1;
    wd_inc     = {1'b0, cur.weekday} + 4'd1;
    wd_wrap    = (wd_inc > DAYS_PER_WEEK) ? (wd_inc - DAYS_PER_WEEK) : wd_inc;
    month_roll = (day_inc > {1'b0, month_len(cur.month)});
    month_inc  = {1'b0, cur.month} + 5'd1;
    year_roll  = month_roll && (month_inc > MONTHS_PER_YEAR);

    ticked             = cur;
    ticked.nanoseconds = ns_wrap[29:0];
    if (sec_carry) begin
      ticked.seconds = sec_wrap[16:0];
    end
    if (day_carry) begin
      ticked.day     = month_roll ? 5'd1 : day_inc[4:0];
      ticked.weekday = wd_wrap[2:0];
      if (month_roll) begin
        ticked.month = year_roll ? 4'd1 : month_inc[3:0];
      end
      if (year_roll) begin
        ticked.year = cur.year + 16'd1;
      end
    end

    case (action)
      ACT_TICK: nxt = ticked;
      ACT_LOAD: nxt = load;
      default:  nxt = cur;
    endcase
  end

endmodule

@@ rtl/tick_calendar_clock.sv @@
// Top level of the time-of-day and calendar counter.
// Depends on tcc_pkg, the interfaces in tcc_if and tcc_next.
//
// Usage:
//   in_if   - one item per transfer: action (tick, load, read) and the
//             load values, which matter only for a load.
//   out_if  - one result per accepted item: the time and date held after
//             that item.
//   cfg_if  - writes tick_ns, the nanoseconds added per tick; always ready.
//             Write it only while no result is pending.
// Latency: the result of an item is valid in the cycle after its transfer.
// Throughput: one item per cycle while out_if takes each result; the single tick
//   carry chain (nanosecond add, second, day, month, year) is combinational
//   and the clock registers themselves hold the result.
// Reset: the clock reads 0 ns, second 0, day 1, weekday 1, month 1,
//   year 0, and tick_ns is 10000000; no result is pending.
// Stall: while a result waits on out_if, in_if stays ready only if the
//   result is taken in the same cycle, so no item is lost or reordered.
module tick_calendar_clock import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tcc_in_if.sink    in_if,
  tcc_out_if.source out_if,
  tcc_cfg_if.sink   cfg_if
);

  clock_state_t state_r;
  clock_state_t state_nxt;
  clock_state_t load;
  logic         out_valid_r;
  logic [29:0]  tick_ns_r;
  logic         in_xfer;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign load.nanoseconds = in_if.load_nanoseconds;
  assign load.seconds     = in_if.load_seconds;
  assign load.day         = in_if.load_day;
  assign load.weekday     = in_if.load_weekday;
  assign load.month       = in_if.load_month;
  assign load.year        = in_if.load_year;

  tcc_next u_next (
    .cur     (state_r),
    .load    (load),
    .action  (in_if.action),
    .tick_ns (tick_ns_r),
    .nxt     (state_nxt)
  );

  // The clock registers double as the result register: they change only
  // on an input transfer, which cannot happen while a result is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.nanoseconds <= '0;
      state_r.seconds     <= '0;
      state_r.day         <= 5'd1;
      state_r.weekday     <= 3'd1;
      state_r.month       <= 4'd1;
      state_r.year        <= '0;
      out_valid_r         <= 1'b0;
      tick_ns_r           <= TICK_RESET;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        tick_ns_r <= cfg_if.data;
      end
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.now_nanoseconds = state_r.nanoseconds;
  assign out_if.now_seconds     = state_r.seconds;
  assign out_if.now_day         = state_r.day;
  assign out_if.now_weekday     = state_r.weekday;
  assign out_if.now_month       = state_r.month;
  assign out_if.now_year        = state_r.year;

endmodule
